### hdl/ipsy_pkg.sv
// Shared types and constants for the indexed pixel stretch YCbCr packer.
package ipsy_pkg;

    // command codes
    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PLAIN    = 2'd0;
    localparam logic [1:0] KIND_BLEND    = 2'd1;
    localparam logic [1:0] KIND_READBACK = 2'd2;

    // register index
    localparam logic REG_STRETCH = 1'b0;

    // output queue
    localparam int OQ_DEPTH = 16;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = OQ_AW + 1;

    // per-item decisions taken at accept time
    typedef struct packed {
        logic readback;
        logic blend_first;
        logic row_end_plain;
        logic blend_after;
        logic set_pending;
    } t_ctrl;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
    } t_ycc;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  kind;
        logic [23:0] rgb;
        logic        row_end;
        logic        last;
    } t_oq_item;

endpackage

### hdl/ipsy_ifs.sv
// Stream interfaces: command items in, packed words out.
interface ipsy_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, command, index, red, green, blue, input ready);
    modport sink   (input valid, command, index, red, green, blue, output ready);
endinterface

interface ipsy_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_word;
    logic [1:0]  word_kind;
    logic [7:0]  read_red;
    logic [7:0]  read_green;
    logic [7:0]  read_blue;
    logic        row_end;
    logic        last;

    modport source (output valid, packed_word, word_kind, read_red, read_green, read_blue,
                    row_end, last, input ready);
    modport sink   (input valid, packed_word, word_kind, read_red, read_green, read_blue,
                    row_end, last, output ready);
endinterface

### hdl/ipsy_palette.sv
// 256 x 24 palette RAM, one write and one registered read per cycle.
module ipsy_palette (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic        i_rd_en,
    input  logic [7:0]  i_addr,
    input  logic [23:0] i_wr_data,
    output logic [23:0] o_rd_data
);

    logic [23:0] r_mem [256];
    logic [23:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/ipsy_convert.sv
// Four-stage RGB to YCbCr pipeline with constant-reciprocal division.
module ipsy_convert (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  ipsy_pkg::t_ctrl      i_ctrl,
    input  logic [23:0]          i_rgb,
    output logic                 o_valid,
    output ipsy_pkg::t_ctrl      o_ctrl,
    output logic [23:0]          o_rgb,
    output ipsy_pkg::t_ycc       o_ycc
);

    localparam int YK_R     = 299;
    localparam int YK_G     = 587;
    localparam int YK_B     = 114;
    localparam int CB_R     = 16874;
    localparam int CB_G     = 33126;
    localparam int CB_B     = 50000;
    localparam int CR_R     = 50000;
    localparam int CR_G     = 41869;
    localparam int CR_B     = 8131;
    localparam int C_OFFSET = 12800000;
    localparam int Y_DIV    = 1000;
    localparam int C_DIV    = 100000;
    // floor(2^SHIFT / DIV); quotient estimate is at most one low
    localparam int Y_SHIFT  = 18;
    localparam int Y_RECIP  = (1 << Y_SHIFT) / Y_DIV;
    localparam int C_SHIFT  = 25;
    localparam int C_RECIP  = (1 << C_SHIFT) / C_DIV;

    logic [7:0] red, green, blue;
    assign red   = i_rgb[23:16];
    assign green = i_rgb[15:8];
    assign blue  = i_rgb[7:0];

    // stage a: products
    logic            r_a_valid;
    ipsy_pkg::t_ctrl r_a_ctrl;
    logic [23:0]     r_a_rgb;
    logic [17:0]     r_py_r, r_py_g, r_py_b;
    logic [23:0]     r_pcb_r, r_pcb_g, r_pcb_b;
    logic [23:0]     r_pcr_r, r_pcr_g, r_pcr_b;

    // stage b: sums
    logic            r_b_valid;
    ipsy_pkg::t_ctrl r_b_ctrl;
    logic [23:0]     r_b_rgb;
    logic [17:0]     r_b_ny;
    logic [24:0]     r_b_ncb, r_b_ncr;

    // stage c: quotient estimates
    logic            r_c_valid;
    ipsy_pkg::t_ctrl r_c_ctrl;
    logic [23:0]     r_c_rgb;
    logic [17:0]     r_c_ny;
    logic [24:0]     r_c_ncb, r_c_ncr;
    logic [7:0]      r_c_qy, r_c_qcb, r_c_qcr;

    // stage d: corrected quotients
    logic            r_d_valid;
    ipsy_pkg::t_ctrl r_d_ctrl;
    logic [23:0]     r_d_rgb;
    ipsy_pkg::t_ycc  r_d_ycc;

    logic [25:0] sum_cb, sum_cr;
    logic [26:0] prod_y;
    logic [33:0] prod_cb, prod_cr;
    logic [17:0] rem_y;
    logic [24:0] rem_cb, rem_cr;

    // sums stay non-negative after the offset; wrap in 26 bits is harmless
    assign sum_cb = 26'(C_OFFSET) + 26'(r_pcb_b) - 26'(r_pcb_r) - 26'(r_pcb_g);
    assign sum_cr = 26'(C_OFFSET) + 26'(r_pcr_r) - 26'(r_pcr_g) - 26'(r_pcr_b);

    assign prod_y  = 27'(r_b_ny) * 27'(Y_RECIP);
    assign prod_cb = 34'(r_b_ncb) * 34'(C_RECIP);
    assign prod_cr = 34'(r_b_ncr) * 34'(C_RECIP);

    assign rem_y  = r_c_ny - 18'(r_c_qy) * 18'(Y_DIV);
    assign rem_cb = r_c_ncb - 25'(r_c_qcb) * 25'(C_DIV);
    assign rem_cr = r_c_ncr - 25'(r_c_qcr) * 25'(C_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ctrl <= i_ctrl;
        r_a_rgb  <= i_rgb;
        r_py_r   <= 18'(red)   * 18'(YK_R);
        r_py_g   <= 18'(green) * 18'(YK_G);
        r_py_b   <= 18'(blue)  * 18'(YK_B);
        r_pcb_r  <= 24'(red)   * 24'(CB_R);
        r_pcb_g  <= 24'(green) * 24'(CB_G);
        r_pcb_b  <= 24'(blue)  * 24'(CB_B);
        r_pcr_r  <= 24'(red)   * 24'(CR_R);
        r_pcr_g  <= 24'(green) * 24'(CR_G);
        r_pcr_b  <= 24'(blue)  * 24'(CR_B);

        r_b_ctrl <= r_a_ctrl;
        r_b_rgb  <= r_a_rgb;
        r_b_ny   <= r_py_r + r_py_g + r_py_b;
        r_b_ncb  <= sum_cb[24:0];
        r_b_ncr  <= sum_cr[24:0];

        r_c_ctrl <= r_b_ctrl;
        r_c_rgb  <= r_b_rgb;
        r_c_ny   <= r_b_ny;
        r_c_ncb  <= r_b_ncb;
        r_c_ncr  <= r_b_ncr;
        r_c_qy   <= prod_y[Y_SHIFT +: 8];
        r_c_qcb  <= prod_cb[C_SHIFT +: 8];
        r_c_qcr  <= prod_cr[C_SHIFT +: 8];

        r_d_ctrl   <= r_c_ctrl;
        r_d_rgb    <= r_c_rgb;
        r_d_ycc.y  <= (rem_y  >= 18'(Y_DIV)) ? r_c_qy  + 8'd1 : r_c_qy;
        r_d_ycc.cb <= (rem_cb >= 25'(C_DIV)) ? r_c_qcb + 8'd1 : r_c_qcb;
        r_d_ycc.cr <= (rem_cr >= 25'(C_DIV)) ? r_c_qcr + 8'd1 : r_c_qcr;
    end

    assign o_valid = r_d_valid;
    assign o_ctrl  = r_d_ctrl;
    assign o_rgb   = r_d_rgb;
    assign o_ycc   = r_d_ycc;

endmodule

### hdl/ipsy_outq.sv
// Result queue taking up to two items per cycle and giving one.
module ipsy_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push_cnt,
    input  ipsy_pkg::t_oq_item          i_item0,
    input  ipsy_pkg::t_oq_item          i_item1,
    input  logic                        i_pop,
    output logic                        o_valid,
    output ipsy_pkg::t_oq_item          o_item,
    output logic [ipsy_pkg::OQ_CW-1:0]  o_count
);

    ipsy_pkg::t_oq_item              r_mem [ipsy_pkg::OQ_DEPTH];
    logic [ipsy_pkg::OQ_AW-1:0]      r_wp, r_rp, n_wp, n_rp, wp_next;
    logic [ipsy_pkg::OQ_CW-1:0]      r_cnt, n_cnt;
    logic                            pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = i_pop && o_valid;
    assign wp_next = r_wp + ipsy_pkg::OQ_AW'(1);

    always_comb begin
        n_wp  = r_wp + ipsy_pkg::OQ_AW'(i_push_cnt);
        n_rp  = pop ? r_rp + ipsy_pkg::OQ_AW'(1) : r_rp;
        n_cnt = r_cnt + ipsy_pkg::OQ_CW'(i_push_cnt) - ipsy_pkg::OQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_item0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wp_next] <= i_item1;
        end
    end

    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

### hdl/indexed_pixel_stretch_ycbcr_packer.sv
// Top level: palette lookup, YCbCr 4:2:2 packing and row stretching.
//
//  channel   dir  modport  handshake      payload
//  i_pix     in   sink     valid/ready    command, index, red, green, blue
//  o_word    out  source   valid/ready    packed_word, word_kind, read_*, row_end, last
//  apb       in   -        psel/penable   paddr[2:0], pwdata/prdata 32b, pready tied high
//
// One item accepted per cycle while the result queue has room for the
// worst case of everything in flight (two words per item). A pixel or
// readback reaches o_word through the palette read, four conversion
// stages and the queue write, all registered. The palette RAM port is the
// only access per item; the single output channel (one word per cycle)
// sets the sustained rate, 1.25 words per pixel in stretch mode.
// Synchronous active-low reset clears counters, flags and the queue and
// turns stretch mode on; the palette holds no reset. Output stalls back
// up into i_pix.ready only.
module indexed_pixel_stretch_ycbcr_packer #(
    parameter int ROW_PIXELS = 256,
    parameter int GROUP_SIZE = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ipsy_in_if.sink           i_pix,
    ipsy_out_if.source        o_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int COL_W = $clog2(ROW_PIXELS);
    localparam int GRP_W = $clog2(GROUP_SIZE);

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    logic r_stretch;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ipsy_pkg::REG_STRETCH);
    assign prdata = (paddr[2] == ipsy_pkg::REG_STRETCH) ? {31'd0, r_stretch} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stretch <= 1'b1;
        end else if (cfg_wr) begin
            r_stretch <= pwdata[0];
        end
    end

    // ---------------------------------------------------------------
    // accept stage: row position and blend decisions
    // ---------------------------------------------------------------
    logic [COL_W-1:0]            r_col, n_col;
    logic [GRP_W-1:0]            r_grp, n_grp;
    logic                        r_blend_pend, n_blend_pend;
    logic [3:0]                  r_inflight, n_inflight;
    logic                        accept, is_pixel, is_read, pipe_in;
    logic                        row_last, group_end, blend_now;
    logic [5:0]                  room_need;
    ipsy_pkg::t_ctrl             acc_ctrl;

    logic                        r_s1_valid;
    ipsy_pkg::t_ctrl             r_s1_ctrl;
    logic [23:0]                 pal_rd_data;

    logic                        cv_valid;
    ipsy_pkg::t_ctrl             cv_ctrl;
    logic [23:0]                 cv_rgb;
    ipsy_pkg::t_ycc              cv_ycc;

    logic [ipsy_pkg::OQ_CW-1:0]  oq_count;

    // every in-flight item may still need two queue slots
    assign room_need   = 6'(oq_count) + 6'({r_inflight, 1'b0}) + 6'd2;
    assign i_pix.ready = (room_need <= 6'(ipsy_pkg::OQ_DEPTH));

    assign accept    = i_pix.valid && i_pix.ready;
    assign is_pixel  = (i_pix.command == ipsy_pkg::CMD_PIXEL);
    assign is_read   = (i_pix.command == ipsy_pkg::CMD_READ);
    assign pipe_in   = accept && (is_pixel || is_read);

    assign row_last  = (r_col == COL_W'(ROW_PIXELS - 1));
    assign group_end = (r_grp == GRP_W'(GROUP_SIZE - 1));
    assign blend_now = r_stretch && group_end;

    always_comb begin
        acc_ctrl               = '0;
        acc_ctrl.readback      = is_read;
        if (is_pixel) begin
            acc_ctrl.blend_first   = r_blend_pend;
            acc_ctrl.row_end_plain = row_last && !blend_now;
            acc_ctrl.blend_after   = row_last && blend_now;
            acc_ctrl.set_pending   = blend_now && !row_last;
        end
    end

    always_comb begin
        n_col        = r_col;
        n_grp        = r_grp;
        n_blend_pend = r_blend_pend;
        if (accept && is_pixel) begin
            n_col        = row_last ? '0 : r_col + COL_W'(1);
            n_grp        = (row_last || group_end) ? '0 : r_grp + GRP_W'(1);
            // a pending blend is always taken by this pixel
            n_blend_pend = blend_now && !row_last;
        end
        n_inflight = r_inflight + 4'(pipe_in) - 4'(cv_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_grp        <= '0;
            r_blend_pend <= 1'b0;
            r_inflight   <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_grp        <= n_grp;
            r_blend_pend <= n_blend_pend;
            r_inflight   <= n_inflight;
            r_s1_valid   <= pipe_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ctrl <= acc_ctrl;
    end

    // ---------------------------------------------------------------
    // palette and conversion
    // ---------------------------------------------------------------
    ipsy_palette u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_pix.command == ipsy_pkg::CMD_WRITE)),
        .i_rd_en   (pipe_in),
        .i_addr    (i_pix.index),
        .i_wr_data ({i_pix.red, i_pix.green, i_pix.blue}),
        .o_rd_data (pal_rd_data)
    );

    ipsy_convert u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_ctrl  (r_s1_ctrl),
        .i_rgb   (pal_rd_data),
        .o_valid (cv_valid),
        .o_ctrl  (cv_ctrl),
        .o_rgb   (cv_rgb),
        .o_ycc   (cv_ycc)
    );

    // ---------------------------------------------------------------
    // word assembly; pending chroma kept as converted values
    // ---------------------------------------------------------------
    ipsy_pkg::t_ycc      r_pend;
    ipsy_pkg::t_oq_item  item0, item1;
    logic [1:0]          push_cnt;
    logic [31:0]         plain_word, blend_word;
    logic [8:0]          cb_sum, cr_sum;

    assign cb_sum     = {1'b0, r_pend.cb} + {1'b0, cv_ycc.cb};
    assign cr_sum     = {1'b0, r_pend.cr} + {1'b0, cv_ycc.cr};
    assign plain_word = {cv_ycc.y, cv_ycc.cb, cv_ycc.y, cv_ycc.cr};
    assign blend_word = {r_pend.y, cb_sum[8:1], cv_ycc.y, cr_sum[8:1]};

    always_comb begin
        item0    = '0;
        item1    = '0;
        push_cnt = 2'd0;
        if (cv_valid) begin
            if (cv_ctrl.readback) begin
                item0.kind = ipsy_pkg::KIND_READBACK;
                item0.rgb  = cv_rgb;
                item0.last = 1'b1;
                push_cnt   = 2'd1;
            end else if (cv_ctrl.blend_first) begin
                // deferred blend, then this pixel's own word
                item0.word    = blend_word;
                item0.kind    = ipsy_pkg::KIND_BLEND;
                item1.word    = plain_word;
                item1.kind    = ipsy_pkg::KIND_PLAIN;
                item1.row_end = cv_ctrl.row_end_plain;
                item1.last    = !cv_ctrl.blend_after;
                push_cnt      = 2'd2;
            end else begin
                item0.word    = plain_word;
                item0.kind    = ipsy_pkg::KIND_PLAIN;
                item0.row_end = cv_ctrl.row_end_plain;
                item0.last    = !cv_ctrl.blend_after;
                push_cnt      = 2'd1;
                if (cv_ctrl.blend_after) begin
                    // row end: blend with itself, same word as plain
                    item1.word    = plain_word;
                    item1.kind    = ipsy_pkg::KIND_BLEND;
                    item1.row_end = 1'b1;
                    item1.last    = 1'b1;
                    push_cnt      = 2'd2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cv_valid && cv_ctrl.set_pending) begin
            r_pend <= cv_ycc;
        end
    end

    // ---------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------
    ipsy_pkg::t_oq_item oq_item;

    ipsy_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_item0    (item0),
        .i_item1    (item1),
        .i_pop      (o_word.ready),
        .o_valid    (o_word.valid),
        .o_item     (oq_item),
        .o_count    (oq_count)
    );

    assign o_word.packed_word = oq_item.word;
    assign o_word.word_kind   = oq_item.kind;
    assign o_word.read_red    = oq_item.rgb[23:16];
    assign o_word.read_green  = oq_item.rgb[15:8];
    assign o_word.read_blue   = oq_item.rgb[7:0];
    assign o_word.row_end     = oq_item.row_end;
    assign o_word.last        = oq_item.last;

endmodule

### hdl/ipsy_checker.sv
// Port-level checks on the packer's result channel, bound to the top level.
module ipsy_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_word,
    input logic [1:0]  i_kind,
    input logic [23:0] i_rgb,
    input logic        i_row_end,
    input logic        i_last
);

    // readback carries the entry only, and is a single result
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == ipsy_pkg::KIND_READBACK)
        |-> (i_word == 32'd0) && !i_row_end && i_last)
        else $error("readback item malformed");

    // pixel words never carry palette colour
    a_pixel_rgb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && ((i_kind == ipsy_pkg::KIND_PLAIN) || (i_kind == ipsy_pkg::KIND_BLEND))
        |-> (i_rgb == 24'd0))
        else $error("pixel item with rgb set");

    // a mid-row blend is always followed by its pixel's plain word
    a_blend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == ipsy_pkg::KIND_BLEND) && !i_row_end |-> !i_last)
        else $error("mid-row blend marked last");

    // nothing queued straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_valid)
        else $error("output valid right after reset");

    // stalled item stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_word) && $stable(i_kind))
        else $error("stalled item dropped or changed");

endmodule

bind indexed_pixel_stretch_ycbcr_packer ipsy_checker u_ipsy_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_word.valid),
    .i_ready   (o_word.ready),
    .i_word    (o_word.packed_word),
    .i_kind    (o_word.word_kind),
    .i_rgb     ({o_word.read_red, o_word.read_green, o_word.read_blue}),
    .i_row_end (o_word.row_end),
    .i_last    (o_word.last)
);
